FILE: design/fbpa_pkg.sv
// fbpa_pkg: shared types and constants of the fixed block pool allocator
// used by fbpa_ctrl and fixed_block_pool_allocator; depends on nothing

package fbpa_pkg;

	localparam int IDX_W    = 10;
	localparam int CNT_W    = 11;
	localparam int STATUS_W = 2;

	localparam logic [CNT_W-1:0] CHUNK_RESET = 11'd16;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_OOM     = 2'd1,
		ST_REFUSED = 2'd2
	} status_t;

	typedef struct packed {
		logic [IDX_W-1:0] granted;
		status_t          status;
		logic [CNT_W-1:0] chunks;
	} result_t;

endpackage

FILE: design/fbpa_ram.sv
// fbpa_ram: generic single write port, single read port ram with registered read
// no dependencies

module fbpa_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/fbpa_ctrl.sv
// fbpa_ctrl: free list, carve frontier and chunk bookkeeping of the allocator
// depends on fbpa_pkg and fbpa_ram (link memory)

module fbpa_ctrl #(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  fbpa_pkg::req_t              req,
	input  logic [fbpa_pkg::IDX_W-1:0]  idx,
	input  logic                        cfg_we,
	input  logic [fbpa_pkg::CNT_W-1:0]  cfg_data,
	output fbpa_pkg::result_t           res
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int XW = (CW > fbpa_pkg::CNT_W) ? CW : fbpa_pkg::CNT_W;
	localparam logic [CW-1:0] RESET_END =
		CW'((int'(fbpa_pkg::CHUNK_RESET) > MAX_BLOCKS) ? MAX_BLOCKS
			: int'(fbpa_pkg::CHUNK_RESET));

	function automatic logic [CW-1:0] eff_chunk(input logic [fbpa_pkg::CNT_W-1:0] cb);
		logic [XW-1:0] wide;
		logic [XW-1:0] lim;
		wide = XW'(cb);
		lim  = XW'(MAX_BLOCKS);
		if (wide == '0) begin
			wide = XW'(1);
		end else if (wide > lim) begin
			wide = lim;
		end
		return CW'(wide);
	endfunction

	logic [fbpa_pkg::CNT_W-1:0] chunk_q;
	logic [IW-1:0]              head_q, head_d;
	logic [IW-1:0]              next_q, next_eff, rd_data;
	logic                       fwd_q;
	logic [CW-1:0]              count_q, count_d;
	logic [CW-1:0]              frontier_q, frontier_d;
	logic [CW-1:0]              end_q, end_d;
	logic [CW-1:0]              total_q, total_d;
	logic [CW-1:0]              eff;
	logic                       need_chunk, fits, refuse, push;
	logic [fbpa_pkg::IDX_W-1:0] grant;
	fbpa_pkg::status_t          status;

	// a push writes the link in the same cycle it would be read, so forward it
	assign next_eff = fwd_q ? next_q : rd_data;

	assign eff        = eff_chunk(chunk_q);
	assign need_chunk = frontier_q >= end_q;
	assign fits       = ({1'b0, end_q} + {1'b0, eff}) <= (CW + 1)'(MAX_BLOCKS);
	assign refuse     = (XW'(idx) >= XW'(frontier_q)) || (XW'(idx) >= XW'(MAX_BLOCKS));

	always_comb begin
		head_d     = head_q;
		count_d    = count_q;
		frontier_d = frontier_q;
		end_d      = end_q;
		total_d    = total_q;
		push       = 1'b0;
		grant      = '0;
		status     = fbpa_pkg::ST_OK;
		// first chunk still untouched: resize it too
		if (cfg_we && frontier_q == '0 && total_q == CW'(1)) begin
			end_d = eff_chunk(cfg_data);
		end
		if (fire) begin
			unique case (req)
				fbpa_pkg::REQ_ALLOC: begin
					priority if (count_q != '0) begin
						grant   = fbpa_pkg::IDX_W'(head_q);
						head_d  = next_eff;
						count_d = count_q - CW'(1);
					end else if (need_chunk && !fits) begin
						status = fbpa_pkg::ST_OOM;
					end else begin
						grant      = fbpa_pkg::IDX_W'(frontier_q);
						frontier_d = frontier_q + CW'(1);
						if (need_chunk) begin
							end_d   = end_q + eff;
							total_d = total_q + CW'(1);
						end
					end
				end
				fbpa_pkg::REQ_FREE: begin
					if (refuse) begin
						status = fbpa_pkg::ST_REFUSED;
					end else begin
						push   = 1'b1;
						head_d = IW'(idx);
						if (count_q != CW'(MAX_BLOCKS)) begin
							count_d = count_q + CW'(1);
						end
					end
				end
			endcase
		end
	end

	assign res.granted = grant;
	assign res.status  = status;
	assign res.chunks  = fbpa_pkg::CNT_W'(total_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q    <= fbpa_pkg::CHUNK_RESET;
			head_q     <= '0;
			next_q     <= '0;
			fwd_q      <= 1'b0;
			count_q    <= '0;
			frontier_q <= '0;
			end_q      <= RESET_END;
			total_q    <= CW'(1);
		end else begin
			head_q     <= head_d;
			count_q    <= count_d;
			frontier_q <= frontier_d;
			total_q    <= total_d;
			fwd_q      <= push;
			end_q      <= end_d;
			if (push) begin
				next_q <= head_q;
			end
			if (cfg_we) begin
				chunk_q <= cfg_data;
			end
		end
	end

	fbpa_ram #(
		.WIDTH (IW),
		.DEPTH (MAX_BLOCKS)
	) u_link (
		.clk   (clk),
		.we    (push),
		.waddr (IW'(idx)),
		.wdata (head_q),
		.raddr (head_d),
		.rdata (rd_data)
	);

endmodule

FILE: design/fixed_block_pool_allocator.sv
// fixed_block_pool_allocator: top level, input and result registers around fbpa_ctrl
// depends on fbpa_pkg, fbpa_ctrl and fbpa_ram
//
// Hands out equal-sized blocks by index from a LIFO free list, carving new
// blocks at a frontier and opening chunks of chunk_blocks blocks as needed.
// Input channel: in_valid / in_stall with req_type (0 allocate, 1 free) and
// block_index. Result channel: out_valid / out_stall with granted_index,
// status (0 ok, 1 out of memory, 2 free refused) and chunks_in_use.
// Every item gives exactly one result, in order.
// An item taken into the input register then passes into the result register,
// which drives the result. Throughput: one item per cycle unless out_stall holds
// the result; the next free-list head comes from the registered read of the link
// memory, with the link written by a push forwarded through a register.
// chunk_blocks is written with cfg_wr_en / cfg_wr_data, by the user while the block
// is idle (unenforced); before anything is carved it also resizes the first chunk.
// Reset (arst_n low): free list empty, frontier zero, one chunk of 16 blocks
// open, chunk_blocks 16. The link memory needs no clearing.
// A stalled result holds; the input register keeps taking items until both
// registers are full, then in_stall rises in the same cycle as out_stall.

module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [fbpa_pkg::IDX_W-1:0]    block_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fbpa_pkg::IDX_W-1:0]    granted_index,
	output logic [fbpa_pkg::STATUS_W-1:0] status,
	output logic [fbpa_pkg::CNT_W-1:0]    chunks_in_use,
	input  logic                          cfg_wr_en,
	input  logic [fbpa_pkg::CNT_W-1:0]    cfg_wr_data
);

	logic                       valid_s1, valid_s2;
	fbpa_pkg::req_t             req_s1;
	logic [fbpa_pkg::IDX_W-1:0] idx_s1;
	fbpa_pkg::result_t          res_c, res_s2;
	logic                       s2_ready, fire;

	assign s2_ready = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && s2_ready;
	assign in_stall = valid_s1 && !s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= fbpa_pkg::req_t'(req_type);
			idx_s1 <= block_index;
		end
		if (fire) begin
			res_s2 <= res_c;
		end
	end

	fbpa_ctrl #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.req      (req_s1),
		.idx      (idx_s1),
		.cfg_we   (cfg_wr_en),
		.cfg_data (cfg_wr_data),
		.res      (res_c)
	);

	assign out_valid     = valid_s2;
	assign granted_index = res_s2.granted;
	assign status        = res_s2.status;
	assign chunks_in_use = res_s2.chunks;

	a_grant_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.status != fbpa_pkg::ST_OK) |-> res_s2.granted == '0)
		else $error("granted index set on a failed request");

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> !in_stall)
		else $error("input stalled with empty result register");

	a_result_leaves_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(valid_s2) |-> $past(!out_stall))
		else $error("result dropped while stalled");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for fixed_block_pool_allocator, a directed table then random phases
// keeps its own free-list and chunk predictor; depends on fbpa_pkg and the design files

module testbench;

	localparam int POOL_BLOCKS  = 1024;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 163;
	localparam int IDLE_PCT     = 34;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t                  kind;
		fbpa_pkg::req_t             req;
		logic [fbpa_pkg::CNT_W-1:0] arg;
		logic                       typed;
		fbpa_pkg::result_t          want;
	} stim_row_t;

	localparam fbpa_pkg::result_t NO_RESULT = '{10'd0, fbpa_pkg::ST_OK, 11'd0};

	localparam logic [0:PHASES-1][fbpa_pkg::CNT_W-1:0] CHUNK_PLAN =
		'{11'd3, 11'd1, 11'd8, 11'd0, 11'd33, 11'd2047, 11'd5, 11'd1024, 11'd2, 11'd0};
	localparam logic [0:PHASES-1][6:0] ALLOC_PCT =
		'{7'd97, 7'd95, 7'd97, 7'd90, 7'd97, 7'd85, 7'd97, 7'd60, 7'd80, 7'd40};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          req_type = 1'b0;
	logic [fbpa_pkg::IDX_W-1:0]    block_index = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [fbpa_pkg::IDX_W-1:0]    granted_index;
	logic [fbpa_pkg::STATUS_W-1:0] status;
	logic [fbpa_pkg::CNT_W-1:0]    chunks_in_use;
	logic                          cfg_wr_en = 1'b0;
	logic [fbpa_pkg::CNT_W-1:0]    cfg_wr_data = '0;

	logic                          calm = 1'b0;
	int unsigned                   cycles = 0;
	int unsigned                   mismatches = 0;
	fbpa_pkg::result_t             expected_results [$];
	fbpa_pkg::result_t             oldest;

	// pool predictor state
	logic [fbpa_pkg::IDX_W-1:0]    pool_links [POOL_BLOCKS];
	logic [fbpa_pkg::IDX_W-1:0]    pool_head;
	int unsigned                   pool_free_cnt;
	int unsigned                   pool_frontier;
	int unsigned                   pool_chunk_end;
	int unsigned                   pool_chunks;
	int unsigned                   pool_chunk_cfg;

	stim_row_t directed_rows [24] = '{
		'{ROW_ITEM, fbpa_pkg::REQ_FREE,  11'd0,    1'b1, '{10'd0, fbpa_pkg::ST_REFUSED, 11'd1}},
		'{ROW_ITEM, fbpa_pkg::REQ_FREE,  11'd1023, 1'b1, '{10'd0, fbpa_pkg::ST_REFUSED, 11'd1}},
		'{ROW_CFG,  fbpa_pkg::REQ_ALLOC, 11'd0,    1'b0, NO_RESULT},
		'{ROW_ITEM, fbpa_pkg::REQ_ALLOC, 11'd0,    1'b1, '{10'd0, fbpa_pkg::ST_OK, 11'd1}},
		'{ROW_ITEM, fbpa_pkg::REQ_ALLOC, 11'd1023, 1'b1, '{10'd1, fbpa_pkg::ST_OK, 11'd2}},
		'{ROW_ITEM, fbpa_pkg::REQ_ALLOC, 11'd0,    1'b1, '{10'd2, fbpa_pkg::ST_OK, 11'd3}},
		'{ROW_ITEM, fbpa_pkg::REQ_FREE,  11'd3,    1'b1, '{10'd0, fbpa_pkg::ST_REFUSED, 11'd3}},
		'{ROW_ITEM, fbpa_pkg::REQ_FREE,  11'd1,    1'b1, '{10'd0, fbpa_pkg::ST_OK, 11'd3}},
		'{ROW_ITEM, fbpa_pkg::REQ_FREE,  11'd2,    1'b1, '{10'd0, fbpa_pkg::ST_OK, 11'd3}},
		'{ROW_ITEM, fbpa_pkg::REQ_ALLOC, 11'd0,    1'b1, '{10'd2, fbpa_pkg::ST_OK, 11'd3}},
		'{ROW_ITEM, fbpa_pkg::REQ_ALLOC, 11'd0,    1'b1, '{10'd1, fbpa_pkg::ST_OK, 11'd3}},
		'{ROW_ITEM, fbpa_pkg::REQ_FREE,  11'd0,    1'b1, '{10'd0, fbpa_pkg::ST_OK, 11'd3}},
		'{ROW_ITEM, fbpa_pkg::REQ_FREE,  11'd0,    1'b1, '{10'd0, fbpa_pkg::ST_OK, 11'd3}},
		'{ROW_ITEM, fbpa_pkg::REQ_ALLOC, 11'd0,    1'b0, NO_RESULT},
		'{ROW_ITEM, fbpa_pkg::REQ_ALLOC, 11'd0,    1'b0, NO_RESULT},
		'{ROW_CFG,  fbpa_pkg::REQ_ALLOC, 11'd2047, 1'b0, NO_RESULT},
		'{ROW_ITEM, fbpa_pkg::REQ_ALLOC, 11'd0,    1'b1, '{10'd0, fbpa_pkg::ST_OOM, 11'd3}},
		'{ROW_ITEM, fbpa_pkg::REQ_FREE,  11'd1023, 1'b1, '{10'd0, fbpa_pkg::ST_REFUSED, 11'd3}},
		'{ROW_CFG,  fbpa_pkg::REQ_ALLOC, 11'd1024, 1'b0, NO_RESULT},
		'{ROW_ITEM, fbpa_pkg::REQ_ALLOC, 11'd0,    1'b1, '{10'd0, fbpa_pkg::ST_OOM, 11'd3}},
		'{ROW_CFG,  fbpa_pkg::REQ_ALLOC, 11'd1,    1'b0, NO_RESULT},
		'{ROW_ITEM, fbpa_pkg::REQ_ALLOC, 11'd0,    1'b0, NO_RESULT},
		'{ROW_ITEM, fbpa_pkg::REQ_FREE,  11'd3,    1'b0, NO_RESULT},
		'{ROW_CFG,  fbpa_pkg::REQ_ALLOC, 11'd16,   1'b0, NO_RESULT}
	};

	fixed_block_pool_allocator #(
		.MAX_BLOCKS(POOL_BLOCKS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.block_index  (block_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.granted_index(granted_index),
		.status       (status),
		.chunks_in_use(chunks_in_use),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned chunk_span();
		int unsigned c;
		c = pool_chunk_cfg;
		if (c < 1) c = 1;
		if (c > POOL_BLOCKS) c = POOL_BLOCKS;
		return c;
	endfunction

	function automatic void pool_reset();
		pool_chunk_cfg = 32'(fbpa_pkg::CHUNK_RESET);
		pool_head      = '0;
		pool_free_cnt  = 0;
		pool_frontier  = 0;
		pool_chunk_end = chunk_span();
		pool_chunks    = 1;
	endfunction

	function automatic void pool_set_chunk(logic [fbpa_pkg::CNT_W-1:0] value);
		pool_chunk_cfg = 32'(value);
		// first chunk still untouched, so it takes the new size
		if (pool_frontier == 0 && pool_chunks == 1) pool_chunk_end = chunk_span();
	endfunction

	function automatic fbpa_pkg::result_t pool_serve(fbpa_pkg::req_t req,
			logic [fbpa_pkg::IDX_W-1:0] idx);
		fbpa_pkg::result_t res;
		res = NO_RESULT;
		if (req == fbpa_pkg::REQ_ALLOC) begin
			if (pool_free_cnt > 0) begin
				res.granted   = pool_head;
				pool_head     = pool_links[pool_head];
				pool_free_cnt = pool_free_cnt - 1;
			end else if (pool_frontier < pool_chunk_end ||
					pool_chunk_end + chunk_span() <= POOL_BLOCKS) begin
				if (pool_frontier >= pool_chunk_end) begin
					pool_chunk_end = pool_chunk_end + chunk_span();
					pool_chunks    = pool_chunks + 1;
				end
				res.granted   = fbpa_pkg::IDX_W'(pool_frontier);
				pool_frontier = pool_frontier + 1;
			end else begin
				res.status = fbpa_pkg::ST_OOM;
			end
		end else if (idx >= pool_frontier) begin
			res.status = fbpa_pkg::ST_REFUSED;
		end else begin
			pool_links[idx] = pool_head;
			pool_head       = idx;
			if (pool_free_cnt < POOL_BLOCKS) pool_free_cnt = pool_free_cnt + 1;
		end
		res.chunks = fbpa_pkg::CNT_W'(pool_chunks);
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
		mismatches++;
	endtask

	task automatic send_item(fbpa_pkg::req_t req, logic [fbpa_pkg::IDX_W-1:0] idx,
			logic typed, fbpa_pkg::result_t want);
		fbpa_pkg::result_t predicted;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= req;
		block_index <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = pool_serve(req, idx);
		if (typed) predicted = want;
		expected_results = {expected_results, predicted};
	endtask

	task automatic write_chunk(logic [fbpa_pkg::CNT_W-1:0] value);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pool_set_chunk(value);
	endtask

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("item with none expected, granted_index",
					int'(granted_index), 0);
			end else begin
				oldest = expected_results.pop_front();
				if (granted_index !== oldest.granted)
					report_mismatch("granted_index", int'(granted_index),
						int'(oldest.granted));
				if (status !== oldest.status)
					report_mismatch("status", int'(status), int'(oldest.status));
				if (chunks_in_use !== oldest.chunks)
					report_mismatch("chunks_in_use", int'(chunks_in_use),
						int'(oldest.chunks));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		fbpa_pkg::req_t             req;
		logic [fbpa_pkg::IDX_W-1:0] idx;
		pool_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_chunk(directed_rows[i].arg);
			else
				send_item(directed_rows[i].req, directed_rows[i].arg[fbpa_pkg::IDX_W-1:0],
					directed_rows[i].typed, directed_rows[i].want);
		end
		for (int p = 0; p < PHASES; p++) begin
			write_chunk((p == PHASES - 1) ? fbpa_pkg::CNT_W'($urandom_range(300, 1))
				: CHUNK_PLAN[p]);
			calm <= (p == 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < ALLOC_PCT[p]) req = fbpa_pkg::REQ_ALLOC;
				else req = fbpa_pkg::REQ_FREE;
				// mostly blocks already carved, sometimes any index
				if (pool_frontier > 0 && $urandom_range(99) < 85)
					idx = fbpa_pkg::IDX_W'($urandom_range(pool_frontier - 1, 0));
				else
					idx = fbpa_pkg::IDX_W'($urandom);
				send_item(req, idx, 1'b0, NO_RESULT);
			end
		end
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
